### rtl/core/lmsd_pkg.sv
// Shared types, codes and lookup functions for the LED matrix scan driver.
// No dependencies; used by every module of the block.
package lmsd_pkg;

    localparam int NumLines = 8;
    localparam int LevelW   = 4;
    localparam int CellW    = 8;
    localparam int LineW    = 3;

    typedef logic [CellW-1:0]     cell_t;
    typedef cell_t [NumLines-1:0] row_t;
    typedef row_t [NumLines-1:0]  frame_t;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_LINE = 2'd1,
        CMD_SET_ALL  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SCAN  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // write strobes broadcast to every row lane
    typedef struct packed {
        logic             set_line;
        logic             set_all;
        logic [LineW-1:0] col;
        cell_t            fill;
    } lane_wr_t;

    typedef struct packed {
        kind_t kind;
        cell_t select;
        row_t  drive;
    } result_t;

    function automatic cell_t bright_curve(input logic [LevelW-1:0] level);
        cell_t v;
        unique case (level)
            4'd0:  v = 8'd0;
            4'd1:  v = 8'd1;
            4'd2:  v = 8'd2;
            4'd3:  v = 8'd4;
            4'd4:  v = 8'd6;
            4'd5:  v = 8'd8;
            4'd6:  v = 8'd12;
            4'd7:  v = 8'd16;
            4'd8:  v = 8'd24;
            4'd9:  v = 8'd32;
            4'd10: v = 8'd48;
            4'd11: v = 8'd64;
            4'd12: v = 8'd96;
            4'd13: v = 8'd128;
            4'd14: v = 8'd192;
            4'd15: v = 8'd255;
        endcase
        return v;
    endfunction

    // active-low select, wired to the board's line order
    function automatic cell_t select_mask(input logic [LineW-1:0] line);
        cell_t m;
        unique case (line)
            3'd0: m = 8'h7F;
            3'd1: m = 8'hDF;
            3'd2: m = 8'hF7;
            3'd3: m = 8'hFD;
            3'd4: m = 8'hBF;
            3'd5: m = 8'hEF;
            3'd6: m = 8'hFB;
            3'd7: m = 8'hFE;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/led_matrix_scan_driver_core.sv
// Top level of the LED matrix scan driver: command decode, row lanes,
// merge stage and a two-entry output buffer. Depends on lmsd_pkg,
// lmsd_lane and lmsd_merge.
//
//  port group          | direction | handshake
//  --------------------+-----------+-------------------------------
//  cmd/line_index/lvl  | in        | in_valid / in_stall
//  kind/select/drive   | out       | out_valid / out_stall
//  cfg_wdata           | in        | cfg_we, single register
//
// One transaction per cycle while in_stall is low; results reach the
// outputs from the output register. The eight row lanes update on the
// edge that takes the input. Reset clears the frame, scan line and verbose
// flag. A spare result register absorbs one result under out_stall;
// in_stall rises only while both result registers are full.
module led_matrix_scan_driver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [3:0] line_index,
    input  logic [3:0] level_0,
    input  logic [3:0] level_1,
    input  logic [3:0] level_2,
    input  logic [3:0] level_3,
    input  logic [3:0] level_4,
    input  logic [3:0] level_5,
    input  logic [3:0] level_6,
    input  logic [3:0] level_7,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] scan_select,
    output logic [7:0] drive_0,
    output logic [7:0] drive_1,
    output logic [7:0] drive_2,
    output logic [7:0] drive_3,
    output logic [7:0] drive_4,
    output logic [7:0] drive_5,
    output logic [7:0] drive_6,
    output logic [7:0] drive_7
);

    logic                         verbose_reg;
    logic [lmsd_pkg::LineW-1:0]   line_reg;
    logic [lmsd_pkg::LineW-1:0]   line_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         skid_valid_reg;
    logic                         skid_valid_next;
    lmsd_pkg::result_t            out_res_reg;
    lmsd_pkg::result_t            out_res_next;
    lmsd_pkg::result_t            skid_res_reg;
    lmsd_pkg::result_t            skid_res_next;

    logic                         in_fire;
    logic                         is_tick;
    logic                         is_write;
    logic                         is_error;
    logic                         produce;
    logic                         out_free;
    lmsd_pkg::kind_t              res_kind;
    lmsd_pkg::lane_wr_t           wr;
    lmsd_pkg::frame_t             rows;
    lmsd_pkg::result_t            new_res;
    logic [lmsd_pkg::NumLines-1:0][lmsd_pkg::LevelW-1:0] levels;

    assign levels = {level_7, level_6, level_5, level_4,
                     level_3, level_2, level_1, level_0};

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;

    // command decode
    always_comb
    begin
        is_tick     = 1'b0;
        is_write    = 1'b0;
        is_error    = 1'b0;
        wr.set_line = 1'b0;
        wr.set_all  = 1'b0;
        wr.col      = line_index[lmsd_pkg::LineW-1:0];
        wr.fill     = lmsd_pkg::bright_curve(level_0);
        unique case (lmsd_pkg::cmd_t'(cmd))
            lmsd_pkg::CMD_TICK:
            begin
                is_tick = 1'b1;
            end
            lmsd_pkg::CMD_SET_LINE:
            begin
                // line index is a hex digit; 8..15 is rejected
                if (line_index[3])
                begin
                    is_error = 1'b1;
                end
                else
                begin
                    is_write    = 1'b1;
                    wr.set_line = in_fire;
                end
            end
            lmsd_pkg::CMD_SET_ALL:
            begin
                is_write   = 1'b1;
                wr.set_all = in_fire;
            end
            default:
            begin
                is_error = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        priority if (is_tick)
        begin
            res_kind = lmsd_pkg::KIND_SCAN;
        end
        else if (is_error)
        begin
            res_kind = lmsd_pkg::KIND_ERROR;
        end
        else
        begin
            res_kind = lmsd_pkg::KIND_ACK;
        end
    end

    assign produce   = in_fire && (is_tick || is_error || (is_write && verbose_reg));
    assign line_next = (in_fire && is_tick) ? line_reg + 1'b1 : line_reg;

    for (genvar r = 0; r < lmsd_pkg::NumLines; r++)
    begin : g_lane
        lmsd_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .wr    (wr),
            .level (levels[r]),
            .cells (rows[r])
        );
    end

    lmsd_merge u_merge (
        .rows (rows),
        .line (line_reg),
        .kind (res_kind),
        .res  (new_res)
    );

    // output register plus one spare entry
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = produce;
                out_res_next   = new_res;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verbose_reg    <= 1'b0;
            line_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                verbose_reg <= cfg_wdata;
            end
            line_reg       <= line_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_res_reg.kind;
    assign scan_select = out_res_reg.select;
    assign drive_0     = out_res_reg.drive[0];
    assign drive_1     = out_res_reg.drive[1];
    assign drive_2     = out_res_reg.drive[2];
    assign drive_3     = out_res_reg.drive[3];
    assign drive_4     = out_res_reg.drive[4];
    assign drive_5     = out_res_reg.drive[5];
    assign drive_6     = out_res_reg.drive[6];
    assign drive_7     = out_res_reg.drive[7];

endmodule

### rtl/core/lmsd_lane.sv
// One row lane: holds the eight brightness cells of a row, maps its level.
// Depends on lmsd_pkg.
module lmsd_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lmsd_pkg::lane_wr_t           wr,
    input  logic [lmsd_pkg::LevelW-1:0]  level,
    output lmsd_pkg::row_t               cells
);

    lmsd_pkg::row_t  cells_reg;
    lmsd_pkg::row_t  cells_next;
    lmsd_pkg::cell_t mapped;

    assign mapped = lmsd_pkg::bright_curve(level);

    always_comb
    begin
        cells_next = cells_reg;
        if (wr.set_all)
        begin
            for (int c = 0; c < lmsd_pkg::NumLines; c++)
            begin
                cells_next[c] = wr.fill;
            end
        end
        else if (wr.set_line)
        begin
            cells_next[wr.col] = mapped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= '0;
        end
        else
        begin
            cells_reg <= cells_next;
        end
    end

    assign cells = cells_reg;

endmodule

### rtl/core/lmsd_merge.sv
// Merge stage: picks the scanned row from the lanes and forms the result.
// Depends on lmsd_pkg.
module lmsd_merge (
    input  lmsd_pkg::frame_t            rows,
    input  logic [lmsd_pkg::LineW-1:0]  line,
    input  lmsd_pkg::kind_t             kind,
    output lmsd_pkg::result_t           res
);

    always_comb
    begin
        res.kind = kind;
        if (kind == lmsd_pkg::KIND_SCAN)
        begin
            res.select = lmsd_pkg::select_mask(line);
            res.drive  = rows[line];
        end
        else
        begin
            // status results carry zero payload
            res.select = '0;
            res.drive  = '0;
        end
    end

endmodule
